@@ design/tsi_pkg.sv @@
// Shared types and constants for the timestamp sync interpolator.
// Used by every module of the block but tsi_ram; depends on nothing.
package tsi_pkg;

	localparam int AXES = 6;
	localparam int STAMP_W = 48;
	localparam int VEL_W = 32;
	localparam int GAP_W = 24;
	localparam int STATUS_W = 3;
	// Bracket spans fit this width; wider spans fall back to front values
	localparam int SPAN_W = 25;
	localparam int PROD_W = VEL_W + SPAN_W + 1;
	localparam logic [STAMP_W-1:0] SPAN_MAX = 48'd33554430;
	localparam logic [GAP_W-1:0] GAP_RESET = 24'd200000;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SYNCED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LATE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FEW = 3'd4;

	typedef logic [AXES-1:0][VEL_W-1:0] vel_vec_t;

	typedef struct packed {
		logic action;
		logic [STAMP_W-1:0] stamp;
		vel_vec_t vel;
	} item_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		vel_vec_t vel;
	} sample_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [STAMP_W-1:0] stamp;
		vel_vec_t vel;
	} result_t;

endpackage

@@ design/tsi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/tsi_front.sv @@
// Front end: two-word input queue that takes pushes and sync queries.
// Depends on tsi_pkg.
module tsi_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  tsi_pkg::item_t in_item,
	output logic           avail,
	output logic           is_sync,
	output tsi_pkg::item_t head_item,
	input  logic           take
);

	tsi_pkg::item_t slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_take;

	assign full = cnt_q == 2'd2;
	assign avail = cnt_q != 2'd0;
	assign head_item = slot_q[rd_q];
	assign is_sync = head_item.action;
	assign do_push = push && !full;
	assign do_take = take && avail;

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= in_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_take) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_take) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_take && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ design/tsi_div.sv @@
// Six-lane radix-2 divider: signed numerator by unsigned span, 32 steps,
// quotient truncated toward zero, positive overflow saturated to 32 bits. Depends on tsi_pkg.
module tsi_div (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [tsi_pkg::AXES-1:0][tsi_pkg::PROD_W-1:0] num,
	input  logic [tsi_pkg::SPAN_W-1:0]                  den,
	output logic                                       done,
	output tsi_pkg::vel_vec_t                          quo
);

	localparam int SW = tsi_pkg::SPAN_W;
	localparam int VW = tsi_pkg::VEL_W;
	localparam int NA = tsi_pkg::AXES;

	logic [NA-1:0][SW-1:0] rem_q;
	logic [NA-1:0][VW-1:0] lo_q;
	logic [NA-1:0]         neg_q;
	logic [SW-1:0]         den_q;
	logic [5:0]            cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [NA-1:0][SW:0]   trial;
	logic [NA-1:0][tsi_pkg::PROD_W-1:0] mag;

	// Per-lane magnitude and trial subtraction
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			mag[i] = num[i][tsi_pkg::PROD_W-1] ? (~num[i] + 1'b1) : num[i];
			trial[i] = {rem_q[i], lo_q[i][VW-1]} - {1'b0, den_q};
		end
	end

	// Load lanes and shift one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int i = 0; i < NA; i++) begin
				neg_q[i] <= num[i][tsi_pkg::PROD_W-1];
				rem_q[i] <= mag[i][VW+SW-1:VW];
				lo_q[i] <= mag[i][VW-1:0];
			end
		end else if (busy_q) begin
			for (int i = 0; i < NA; i++) begin
				if (!trial[i][SW]) begin
					rem_q[i] <= trial[i][SW-1:0];
					lo_q[i] <= {lo_q[i][VW-2:0], 1'b1};
				end else begin
					rem_q[i] <= {rem_q[i][SW-2:0], lo_q[i][VW-1]};
					lo_q[i] <= {lo_q[i][VW-2:0], 1'b0};
				end
			end
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(VW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restore sign and clamp positive overflow
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			if (neg_q[i]) begin
				quo[i] = ~lo_q[i] + 1'b1;
			end else if (lo_q[i][VW-1]) begin
				quo[i] = {1'b0, {(VW-1){1'b1}}};
			end else begin
				quo[i] = lo_q[i];
			end
		end
	end

	assign done = done_q;

endmodule

@@ design/tsi_back.sv @@
// Back end: sample store, sync search sequencer, shared multiplier and
// divider hand-off. Depends on tsi_pkg, tsi_ram and tsi_div.
module tsi_back #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         avail,
	input  logic                         is_sync,
	input  tsi_pkg::item_t               item,
	output logic                         take,
	input  logic [tsi_pkg::GAP_W-1:0]    max_gap,
	input  logic                         out_free,
	output logic                         res_valid,
	output tsi_pkg::result_t             res
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SMP_W = $bits(tsi_pkg::sample_t);
	localparam int SW = tsi_pkg::SPAN_W;
	localparam int PW = tsi_pkg::PROD_W;
	localparam int TW = tsi_pkg::STAMP_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SYNC = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_MUL = 3'd3;
	localparam logic [2:0] S_DIV = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic          final_q;
	logic [TW-1:0] ts_q;
	logic [SW-1:0] wa_q, wb_q, span_q;
	logic [2:0]    axis_q;
	logic          phase_q;
	logic [PW-1:0] prod_q;
	logic [tsi_pkg::AXES-1:0][PW-1:0] num_q;
	logic          div_start_q;

	tsi_pkg::sample_t smp_a, smp_b, wr_smp;
	logic [AW-1:0] waddr, next_addr;
	logic          we, q_full, div_done, start_div;
	logic          drop_front;
	logic [TW-1:0] t0, t1;
	logic          late, stale, gap_far, front_only;
	logic [tsi_pkg::VEL_W-1:0] mul_v;
	logic [SW-1:0] mul_w;
	logic [PW-1:0] prod;
	tsi_pkg::vel_vec_t quo;

	function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
		logic [CW:0] r;
		r = (s >= (CW+1)'(QUEUE_DEPTH)) ? s - (CW+1)'(QUEUE_DEPTH) : s;
		return r[AW-1:0];
	endfunction

	// Push address: tail, or the head slot when the oldest word is dropped
	assign q_full = count_q == CW'(QUEUE_DEPTH);
	assign waddr = q_full ? head_q : wrap((CW+1)'(head_q) + (CW+1)'(count_q));
	assign next_addr = wrap((CW+1)'(head_q) + (CW+1)'(1));
	assign wr_smp = '{stamp: item.stamp, vel: item.vel};
	assign take = (state_q == S_IDLE) && avail && out_free && !is_sync;
	assign we = take;

	tsi_ram #(.WIDTH(SMP_W), .DEPTH(QUEUE_DEPTH)) u_ram_a (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wr_smp),
		.raddr(head_q), .rdata(smp_a)
	);

	tsi_ram #(.WIDTH(SMP_W), .DEPTH(QUEUE_DEPTH)) u_ram_b (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wr_smp),
		.raddr(next_addr), .rdata(smp_b)
	);

	// Neighbour tests on the two front words
	assign t0 = smp_a.stamp;
	assign t1 = smp_b.stamp;
	assign late = t0 > ts_q;
	assign stale = t1 < ts_q;
	assign gap_far = ((ts_q - t0) > TW'(max_gap)) || ((t1 - ts_q) > TW'(max_gap));
	assign front_only = (t1 <= t0) || (ts_q < t0) || (ts_q > t1)
		|| ((t1 - t0) > tsi_pkg::SPAN_MAX);
	assign drop_front = (state_q == S_EVAL) && !final_q && !late && (stale || gap_far);

	// Shared multiplier: v0*wa then v1*wb per axis
	assign mul_v = phase_q ? smp_b.vel[axis_q] : smp_a.vel[axis_q];
	assign mul_w = phase_q ? wb_q : wa_q;
	assign prod = PW'($signed(mul_v)) * PW'($signed({1'b0, mul_w}));
	assign start_div = (state_q == S_MUL) && phase_q && (axis_q == 3'(tsi_pkg::AXES - 1));

	// Divider starts the cycle after the last numerator is stored
	tsi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .num(num_q),
		.den(span_q), .done(div_done), .quo(quo)
	);

	// Hold operands and accumulate numerators
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			ts_q <= item.stamp;
		end
		if (state_q == S_EVAL) begin
			wa_q <= SW'(t1 - ts_q);
			wb_q <= SW'(ts_q - t0);
			span_q <= SW'(t1 - t0);
		end
		if (state_q == S_MUL) begin
			if (!phase_q) begin
				prod_q <= prod;
			end else begin
				num_q[axis_q] <= prod_q + prod;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			final_q <= 1'b0;
			axis_q <= 3'd0;
			phase_q <= 1'b0;
			div_start_q <= 1'b0;
			res_valid <= 1'b0;
			res <= '0;
		end else begin
			res_valid <= 1'b0;
			div_start_q <= start_div;
			unique case (state_q)
				S_IDLE: begin
					if (avail && out_free) begin
						res <= '0;
						if (is_sync) begin
							final_q <= 1'b0;
							state_q <= S_SYNC;
						end else begin
							res_valid <= 1'b1;
							if (q_full) begin
								head_q <= next_addr;
								res.status <= tsi_pkg::ST_DROPPED;
							end else begin
								count_q <= count_q + CW'(1);
								res.status <= tsi_pkg::ST_STORED;
							end
						end
					end
				end
				S_SYNC: begin
					if (count_q < CW'(2)) begin
						res.status <= tsi_pkg::ST_FEW;
						res_valid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!final_q && late) begin
						res.status <= tsi_pkg::ST_LATE;
						res_valid <= 1'b1;
						state_q <= S_IDLE;
					end else if (drop_front) begin
						head_q <= next_addr;
						count_q <= count_q - CW'(1);
						final_q <= !stale;
						state_q <= S_SYNC;
					end else if (front_only) begin
						res.status <= tsi_pkg::ST_SYNCED;
						res.stamp <= ts_q;
						res.vel <= smp_a.vel;
						res_valid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						axis_q <= 3'd0;
						phase_q <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						axis_q <= axis_q + 3'd1;
						if (start_div) begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						res.status <= tsi_pkg::ST_SYNCED;
						res.stamp <= ts_q;
						res.vel <= quo;
						res_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The sync query leaves the input queue together with its result
	logic sync_done;
	assign sync_done = res_valid && (res.status != tsi_pkg::ST_STORED)
		&& (res.status != tsi_pkg::ST_DROPPED);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("sample count beyond queue depth");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");

	a_push_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> res_valid && !sync_done)
		else $error("push did not give a store result");

	a_drop_keeps_pair: assert property (@(posedge clk) disable iff (!arst_n)
		drop_front |-> count_q >= CW'(2))
		else $error("front dropped with fewer than two samples");

endmodule

@@ design/timestamp_sync_interpolator_unit.sv @@
// Top level of the timestamp sync interpolator: input queue, back end
// and result register. Depends on tsi_pkg, tsi_front and tsi_back.
//
//   channel   | handshake        | words
//   ----------+------------------+-----------------------------------------
//   input     | push / full      | action, stamp, lin_*, ang_*
//   result    | pop / empty      | status, out_stamp, out_lin_*, out_ang_*
//   config    | max_gap_we       | max_gap_wdata
//
// A push is stored when the back end takes it; its result is registered in the
// back end and then in the result register. A sync query passes the sync state to
// the first check, again per front sample dropped (registered store read), then the
// shared multiplier and the divide state (start, 32 steps, hand-off).
// Reset clears queue pointers and counts; the sample store needs no clearing.
// The back end starts a new word only once the previous result is popped; the
// input queue holds two words, so input is taken while a result waits.
module timestamp_sync_interpolator_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [47:0] stamp,
	input  logic signed [31:0] lin_x,
	input  logic signed [31:0] lin_y,
	input  logic signed [31:0] lin_z,
	input  logic signed [31:0] ang_x,
	input  logic signed [31:0] ang_y,
	input  logic signed [31:0] ang_z,
	input  logic        max_gap_we,
	input  logic [23:0] max_gap_wdata,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [47:0] out_stamp,
	output logic signed [31:0] out_lin_x,
	output logic signed [31:0] out_lin_y,
	output logic signed [31:0] out_lin_z,
	output logic signed [31:0] out_ang_x,
	output logic signed [31:0] out_ang_y,
	output logic signed [31:0] out_ang_z
);

	tsi_pkg::item_t   in_item, head_item;
	tsi_pkg::result_t res, out_q;
	logic             avail, is_sync, take, res_valid, out_valid_q;
	logic [23:0]      max_gap_q;
	logic             back_take;
	logic             sync_res;

	assign in_item = '{action: action, stamp: stamp,
		vel: {ang_z, ang_y, ang_x, lin_z, lin_y, lin_x}};

	tsi_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.avail(avail), .is_sync(is_sync), .head_item(head_item), .take(back_take)
	);

	// Sync queries leave the input queue when their result is issued
	assign sync_res = res_valid && (res.status != tsi_pkg::ST_STORED)
		&& (res.status != tsi_pkg::ST_DROPPED);

	tsi_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .avail(avail), .is_sync(is_sync),
		.item(head_item), .take(take), .max_gap(max_gap_q),
		.out_free(!out_valid_q && !res_valid), .res_valid(res_valid), .res(res)
	);

	assign back_take = take || sync_res;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= tsi_pkg::GAP_RESET;
		end else if (max_gap_we) begin
			max_gap_q <= max_gap_wdata;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign empty = !out_valid_q;
	assign status = out_q.status;
	assign out_stamp = out_q.stamp;
	assign out_lin_x = out_q.vel[0];
	assign out_lin_y = out_q.vel[1];
	assign out_lin_z = out_q.vel[2];
	assign out_ang_x = out_q.vel[3];
	assign out_ang_y = out_q.vel[4];
	assign out_ang_z = out_q.vel[5];

endmodule
